/* rtl/rsa_pkg.sv */
// Shared types and constants for the running statistics accumulator.
// No dependencies; used by rsa_stream_if and running_statistics_accumulator_unit.
package rsa_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 32;
	localparam int SUM_W    = 48;
	localparam int SSQ_W    = 63;
	localparam int VAR_W    = 31;
	localparam int ROOT_W   = 16;
	localparam int DIV_W    = 64;
	localparam int REM_W    = 32;
	localparam int MUL_W    = 32;
	localparam int STEP_W   = 6;
	localparam int DIV_STEPS  = 64;
	localparam int ROOT_STEPS = 16;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] MIN_RST = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] MAX_RST = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [VAR_W-1:0]           VAR_MAX = {VAR_W{1'b1}};

	typedef struct packed {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] sample;
	} rsa_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]         sample_count;
		logic signed [SAMPLE_W-1:0] mean_value;
		logic signed [SAMPLE_W-1:0] min_value;
		logic signed [SAMPLE_W-1:0] max_value;
		logic [VAR_W-1:0]           variance_value;
		logic [ROOT_W-1:0]          std_dev_value;
		logic signed [SAMPLE_W-1:0] last_value;
		logic                       saturated;
	} rsa_stats_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_UPD,
		S_ACC,
		S_DIV1,
		S_MEAN,
		S_MQQ,
		S_MQQN,
		S_MQR,
		S_MRR,
		S_LD2,
		S_DIV2,
		S_ADDQ,
		S_LD3,
		S_DIV3,
		S_FIX,
		S_SQRT,
		S_OUT
	} rsa_state_t;

endpackage

/* rtl/rsa_stream_if.sv */
// Valid/ready request channel carrying one payload item.
// Depends on rsa_pkg for the default payload type.
interface rsa_stream_if #(
	parameter type item_t = rsa_pkg::rsa_item_t
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/running_statistics_accumulator_unit.sv */
// Running statistics accumulator: count, mean, variance, std dev, min, max, last.
// With two or more samples the result takes three 64-step divisions on the shared
// subtractor plus a 16-step square root; with one sample only the first division,
// and none when empty. One request is in work at a time; the next is taken the
// cycle after the result is loaded.
// Reset (arst_n, asynchronous) clears all statistics to their empty values.
module running_statistics_accumulator_unit (
	input  logic        clk,
	input  logic        arst_n,
	rsa_stream_if.sink   item,
	rsa_stream_if.source stats
);
	import rsa_pkg::*;

	rsa_state_t state_q, state_d;

	logic [COUNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SSQ_W-1:0]           ssq_q;
	logic signed [SAMPLE_W-1:0] min_q, max_q, last_q, smp_q;
	logic                       clr_q, sat_q, neg_q, rnz_q, ovld_q;

	logic [DIV_W-1:0]    prod_q, acc_q, quo_q;
	logic [REM_W-1:0]    rem_q, div_q, ra_q;
	logic [ROOT_W-1:0]   qa_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [VAR_W-1:0]    var_q;
	logic [MUL_W-1:0]    sq_v_q, sq_res_q, sq_bit_q;
	logic [STEP_W-1:0]   cnt_q;
	rsa_stats_t          odata_q;

	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [REM_W:0]      sub_a, sub_b;
	logic [REM_W+1:0]    diff;
	logic                ge;
	logic [SAMPLE_W:0]   mv;
	logic [SUM_W-1:0]    sum_mag;
	logic [DIV_W-1:0]    hi_adj;
	logic                div_last, root_last, out_load;

	assign mv      = smp_q[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, smp_q}) : {1'b0, smp_q};
	assign sum_mag = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
	assign div_last  = (cnt_q == STEP_W'(DIV_STEPS - 1));
	assign root_last = (cnt_q == STEP_W'(ROOT_STEPS - 1));
	assign out_load  = (state_q == S_OUT) && (!ovld_q || stats.ready);

	assign hi_adj = ((rem_q == '0) && rnz_q && (quo_q != '0)) ? (quo_q - DIV_W'(1)) : quo_q;

	always_comb begin
		unique case (state_q)
			S_UPD: begin
				mul_a = MUL_W'(mv);
				mul_b = MUL_W'(mv);
			end
			S_MQQ: begin
				mul_a = MUL_W'(qa_q);
				mul_b = MUL_W'(qa_q);
			end
			S_MQQN: begin
				mul_a = prod_q[MUL_W-1:0];
				mul_b = count_q;
			end
			S_MQR: begin
				mul_a = MUL_W'(qa_q);
				mul_b = ra_q;
			end
			S_MRR: begin
				mul_a = ra_q;
				mul_b = ra_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_SQRT) begin
			sub_a = {1'b0, sq_v_q};
			sub_b = {1'b0, sq_res_q | sq_bit_q};
		end else begin
			sub_a = {rem_q, quo_q[DIV_W-1]};
			sub_b = {1'b0, div_q};
		end
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		ge   = !diff[REM_W+1];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (item.valid) state_d = S_UPD;
			S_UPD:  state_d = S_ACC;
			S_ACC:  state_d = (count_q == '0) ? S_OUT : S_DIV1;
			S_DIV1: if (div_last) state_d = S_MEAN;
			S_MEAN: state_d = (count_q[COUNT_W-1:1] == '0) ? S_OUT : S_MQQ;
			S_MQQ:  state_d = S_MQQN;
			S_MQQN: state_d = S_MQR;
			S_MQR:  state_d = S_MRR;
			S_MRR:  state_d = S_LD2;
			S_LD2:  state_d = S_DIV2;
			S_DIV2: if (div_last) state_d = S_ADDQ;
			S_ADDQ: state_d = S_LD3;
			S_LD3:  state_d = S_DIV3;
			S_DIV3: if (div_last) state_d = S_FIX;
			S_FIX:  state_d = S_SQRT;
			S_SQRT: if (root_last) state_d = S_OUT;
			S_OUT:  if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign item.ready  = (state_q == S_IDLE);
	assign stats.valid = ovld_q;
	assign stats.data  = odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				ovld_q <= 1'b1;
			end else if (stats.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ssq_q   <= '0;
			min_q   <= MIN_RST;
			max_q   <= MAX_RST;
			last_q  <= '0;
		end else if (state_q == S_UPD) begin
			if (clr_q == KIND_CLEAR) begin
				count_q <= '0;
				sum_q   <= '0;
				ssq_q   <= '0;
				min_q   <= MIN_RST;
				max_q   <= MAX_RST;
				last_q  <= '0;
			end else if (count_q != '1) begin
				count_q <= count_q + COUNT_W'(1);
				sum_q   <= sum_q + SUM_W'(smp_q);
				last_q  <= smp_q;
				if (smp_q < min_q) begin
					min_q <= smp_q;
				end
				if (smp_q > max_q) begin
					max_q <= smp_q;
				end
			end
		end else if (state_q == S_ACC && !sat_q && clr_q != KIND_CLEAR) begin
			ssq_q <= ssq_q + SSQ_W'(prod_q);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= DIV_W'(mul_a) * DIV_W'(mul_b);
		unique case (state_q)
			S_IDLE: begin
				smp_q <= item.data.sample;
				clr_q <= item.data.kind;
				sat_q <= 1'b0;
			end
			S_UPD: begin
				if (clr_q != KIND_CLEAR && count_q == '1) begin
					sat_q <= 1'b1;
				end
			end
			S_ACC: begin
				mean_q   <= '0;
				var_q    <= '0;
				sq_res_q <= '0;
				neg_q    <= sum_q[SUM_W-1];
				quo_q    <= DIV_W'(sum_mag);
				rem_q    <= '0;
				div_q    <= count_q;
				cnt_q    <= '0;
			end
			S_DIV1, S_DIV2, S_DIV3: begin
				rem_q <= ge ? diff[REM_W-1:0] : sub_a[REM_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ge};
				cnt_q <= cnt_q + STEP_W'(1);
			end
			S_MEAN: begin
				qa_q   <= quo_q[ROOT_W-1:0];
				ra_q   <= rem_q;
				mean_q <= neg_q ? (SAMPLE_W'(0) - quo_q[SAMPLE_W-1:0]) : quo_q[SAMPLE_W-1:0];
			end
			S_MQR: begin
				acc_q <= prod_q;
			end
			S_MRR: begin
				acc_q <= acc_q + {prod_q[DIV_W-2:0], 1'b0};
			end
			S_LD2: begin
				quo_q <= prod_q;
				rem_q <= '0;
				div_q <= count_q;
				cnt_q <= '0;
			end
			S_ADDQ: begin
				acc_q <= acc_q + quo_q;
				rnz_q <= (rem_q != '0);
			end
			S_LD3: begin
				quo_q <= DIV_W'(ssq_q - acc_q[SSQ_W-1:0]);
				rem_q <= '0;
				div_q <= count_q - COUNT_W'(1);
				cnt_q <= '0;
			end
			S_FIX: begin
				var_q    <= (hi_adj > DIV_W'(VAR_MAX)) ? VAR_MAX : hi_adj[VAR_W-1:0];
				sq_v_q   <= (hi_adj > DIV_W'(VAR_MAX)) ? MUL_W'(VAR_MAX)
				                                       : MUL_W'(hi_adj[VAR_W-1:0]);
				sq_res_q <= '0;
				sq_bit_q <= MUL_W'(1) << (2 * ROOT_STEPS - 2);
				cnt_q    <= '0;
			end
			S_SQRT: begin
				if (ge) begin
					sq_v_q   <= diff[MUL_W-1:0];
					sq_res_q <= (sq_res_q >> 1) | sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				cnt_q    <= cnt_q + STEP_W'(1);
			end
			S_OUT: begin
				if (out_load) begin
					odata_q.sample_count   <= count_q;
					odata_q.mean_value     <= mean_q;
					odata_q.min_value      <= min_q;
					odata_q.max_value      <= max_q;
					odata_q.variance_value <= var_q;
					odata_q.std_dev_value  <= sq_res_q[ROOT_W-1:0];
					odata_q.last_value     <= last_q;
					odata_q.saturated      <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* test/tb.sv */
// Self-checking bench for running_statistics_accumulator_unit: a table of requests,
// then random ones, each checked against its table row or an in-bench predictor.
// Depends on rsa_pkg, rsa_stream_if and the accumulator RTL.
module tb;
	import rsa_pkg::*;

	localparam int     IDLE_LIMIT   = 20000;
	localparam int     LONG_HOLD    = 3000;
	localparam int     RANDOM_ITEMS = 700;
	localparam longint COUNT_FULL   = (longint'(1) << COUNT_W) - 1;

	typedef struct {
		logic                kind;
		logic [SAMPLE_W-1:0] sample;
		bit                  typed;
		rsa_stats_t          want;
	} script_row_t;

	logic clk;
	logic arst_n;

	rsa_stream_if #(.item_t(rsa_item_t))  item_ch ();
	rsa_stream_if #(.item_t(rsa_stats_t)) stats_ch ();

	running_statistics_accumulator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.stats  (stats_ch)
	);

	longint                     acc_count;
	longint                     acc_sum;
	longint                     acc_sumsq;
	logic signed [SAMPLE_W-1:0] acc_min;
	logic signed [SAMPLE_W-1:0] acc_max;
	logic signed [SAMPLE_W-1:0] acc_last;

	rsa_stats_t                 pending_stats [$];
	int                         mismatches = 0;
	bit                         calm = 0;
	bit                         hold_request = 0;
	logic [SAMPLE_W-1:0]        cluster_base = '0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void clear_stats();
		acc_count = 0;
		acc_sum   = 0;
		acc_sumsq = 0;
		acc_min   = MIN_RST;
		acc_max   = MAX_RST;
		acc_last  = '0;
	endfunction

	function automatic longint floor_root(input longint v);
		longint lo;
		longint hi;
		longint mid;
		lo = 0;
		hi = 46341;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic rsa_stats_t accumulate(input rsa_item_t it);
		rsa_stats_t          r;
		logic signed [127:0] n;
		logic signed [127:0] num;
		logic signed [127:0] quot;
		longint              v;
		longint              variance;
		bit                  full;
		full = 1'b0;
		if (it.kind == KIND_CLEAR) begin
			clear_stats();
		end else if (acc_count >= COUNT_FULL) begin
			full = 1'b1;
		end else begin
			v = it.sample;
			acc_count = acc_count + 1;
			acc_sum   = acc_sum + v;
			acc_sumsq = acc_sumsq + v * v;
			acc_last  = it.sample;
			if (it.sample < acc_min) acc_min = it.sample;
			if (it.sample > acc_max) acc_max = it.sample;
		end
		variance = 0;
		if (acc_count >= 2) begin
			n    = acc_count;
			num  = n * 128'(acc_sumsq) - 128'(acc_sum) * 128'(acc_sum);
			quot = num / (n * (n - 1));
			variance = (quot > longint'(VAR_MAX)) ? longint'(VAR_MAX) : longint'(quot);
		end
		r.sample_count   = acc_count[COUNT_W-1:0];
		r.mean_value     = (acc_count == 0) ? '0 : SAMPLE_W'(acc_sum / acc_count);
		r.min_value      = acc_min;
		r.max_value      = acc_max;
		r.variance_value = VAR_W'(variance);
		r.std_dev_value  = ROOT_W'(floor_root(variance));
		r.last_value     = acc_last;
		r.saturated      = full;
		return r;
	endfunction

	function automatic rsa_stats_t stats_of(input longint count, input longint mean,
			input longint min_v, input longint max_v, input longint variance,
			input longint root, input longint last_v);
		rsa_stats_t r;
		r.sample_count   = COUNT_W'(count);
		r.mean_value     = SAMPLE_W'(mean);
		r.min_value      = SAMPLE_W'(min_v);
		r.max_value      = SAMPLE_W'(max_v);
		r.variance_value = VAR_W'(variance);
		r.std_dev_value  = ROOT_W'(root);
		r.last_value     = SAMPLE_W'(last_v);
		r.saturated      = 1'b0;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(50, 400);
	endfunction

	function automatic rsa_item_t make_item();
		rsa_item_t it;
		int        mode;
		mode      = $urandom_range(0, 99);
		it.kind   = KIND_SAMPLE;
		it.sample = SAMPLE_W'($urandom);
		if (mode < 3) begin
			it.kind = KIND_CLEAR;
		end else if (mode < 10) begin
			it.sample = ($urandom_range(0, 1) != 0) ? MIN_RST : MAX_RST;
		end else if (mode < 35) begin
			it.sample = SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
		end else if (mode < 60) begin
			if ($urandom_range(0, 15) == 0) cluster_base = SAMPLE_W'($urandom);
			it.sample = cluster_base + SAMPLE_W'($urandom_range(0, 8));
		end
		return it;
	endfunction

	task automatic offer(input rsa_item_t it, input bit typed, input rsa_stats_t want);
		int         gap;
		rsa_stats_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		predicted = accumulate(it);
		pending_stats.push_back(typed ? want : predicted);
	endtask

	task automatic match(input string field, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		rsa_stats_t want;
		if (arst_n && stats_ch.valid && stats_ch.ready) begin
			if (pending_stats.size() == 0) begin
				$error("result with no request waiting, sample_count %0d",
					stats_ch.data.sample_count);
				mismatches++;
			end else begin
				want = pending_stats.pop_front();
				match("sample_count", want.sample_count, stats_ch.data.sample_count);
				match("mean_value", $signed(want.mean_value),
					$signed(stats_ch.data.mean_value));
				match("min_value", $signed(want.min_value),
					$signed(stats_ch.data.min_value));
				match("max_value", $signed(want.max_value),
					$signed(stats_ch.data.max_value));
				match("variance_value", want.variance_value,
					stats_ch.data.variance_value);
				match("std_dev_value", want.std_dev_value, stats_ch.data.std_dev_value);
				match("last_value", $signed(want.last_value),
					$signed(stats_ch.data.last_value));
				match("saturated", want.saturated, stats_ch.data.saturated);
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				stats_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 0;
				stall = LONG_HOLD - 1;
				stats_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
				stats_ch.ready <= (stall == 0);
				if (stall > 0) stall--;
			end else begin
				stats_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (stats_ch.valid && stats_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		script_row_t script [$];
		rsa_item_t   it;
		rsa_stats_t  blank;
		arst_n         = 1'b0;
		item_ch.valid  = 1'b0;
		item_ch.data   = '0;
		stats_ch.ready = 1'b0;
		clear_stats();
		blank = stats_of(0, 0, MIN_RST, MAX_RST, 0, 0, 0);

		script.push_back('{KIND_CLEAR,  16'h0000, 1'b1, blank});
		script.push_back('{KIND_SAMPLE, 16'h7FFF, 1'b1,
			stats_of(1, 32767, 32767, 32767, 0, 0, 32767)});
		script.push_back('{KIND_SAMPLE, 16'h8000, 1'b1,
			stats_of(2, 0, -32768, 32767, 2147418112, 46340, -32768)});
		script.push_back('{KIND_CLEAR,  16'h7FFF, 1'b1, blank});
		script.push_back('{KIND_SAMPLE, 16'h8000, 1'b1,
			stats_of(1, -32768, -32768, -32768, 0, 0, -32768)});
		script.push_back('{KIND_SAMPLE, 16'h8000, 1'b1,
			stats_of(2, -32768, -32768, -32768, 0, 0, -32768)});
		script.push_back('{KIND_SAMPLE, 16'h0000, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'hFFFF, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'h0001, 1'b0, blank});
		script.push_back('{KIND_CLEAR,  16'h8000, 1'b1, blank});
		script.push_back('{KIND_CLEAR,  16'hFFFF, 1'b1, blank});
		script.push_back('{KIND_SAMPLE, 16'h0000, 1'b1, stats_of(1, 0, 0, 0, 0, 0, 0)});
		script.push_back('{KIND_SAMPLE, 16'h0003, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'hFFFB, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'h0007, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'hFFFE, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'h5555, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'hAAAA, 1'b0, blank});
		script.push_back('{KIND_CLEAR,  16'h0000, 1'b1, blank});
		script.push_back('{KIND_SAMPLE, 16'hFFFF, 1'b1,
			stats_of(1, -1, -1, -1, 0, 0, -1)});
		script.push_back('{KIND_SAMPLE, 16'hFFFE, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'h7FFF, 1'b0, blank});
		script.push_back('{KIND_SAMPLE, 16'h7FFF, 1'b0, blank});
		script.push_back('{KIND_CLEAR,  16'h0000, 1'b1, blank});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			it.kind   = script[i].kind;
			it.sample = script[i].sample;
			offer(it, script[i].typed, script[i].want);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 150) hold_request = 1;
			if (i == 300) begin
				// drain before the next request
				item_ch.valid <= 1'b0;
				while (pending_stats.size() != 0) @(posedge clk);
			end
			calm = (i >= 420 && i < 470);
			offer(make_item(), 1'b0, blank);
		end
		item_ch.valid <= 1'b0;

		while (pending_stats.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rsa_pkg.sv
rtl/rsa_stream_if.sv
rtl/running_statistics_accumulator_unit.sv
test/tb.sv
